### hdl/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package skt_pkg;
   localparam int KeyWidth  = 32;
   localparam int NameWidth = 152;
   localparam int PosWidth  = 6;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_LOOKUP = 2'd2,
      REQ_LIST   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_DUP      = 3'd3,
      ST_FULL     = 3'd4,
      ST_BADKEY   = 3'd5
   } status_type;

   typedef struct packed {
      logic [KeyWidth-1:0]  key;
      logic [NameWidth-1:0] name;
      logic                 gender;
   } record_type;

   // shift command broadcast to every cell
   typedef struct packed {
      logic       insert;
      logic       remove;
      record_type data;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LIST,
      S_OUT
   } state_type;
endpackage
`default_nettype wire

### hdl/skt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module skt_cell (
   input  wire logic               clock,
   input  wire skt_pkg::cell_cmd_type cmd,
   input  wire logic               valid,
   input  wire logic               left_valid,
   input  wire logic               left_greater,
   input  wire skt_pkg::record_type left_data,
   input  wire skt_pkg::record_type right_data,
   output logic                    greater,
   output logic                    match,
   output skt_pkg::record_type     data
);
   import skt_pkg::*;
   record_type data_ff, data_in;

   assign data    = data_ff;
   // stored key larger than the command key; invalid cells count as larger
   assign greater = !valid || (data_ff.key > cmd.data.key);
   assign match   = valid && (data_ff.key == cmd.data.key);

   always_comb begin
      data_in = data_ff;
      if (cmd.insert) begin
         if (greater) begin
            // left neighbour greater too: take its record, else take new one
            if (left_valid && left_greater) data_in = left_data;
            else data_in = cmd.data;
         end
      end else if (cmd.remove) begin
         // shift down from the match point onward
         if (match || (left_valid && (left_data.key >= cmd.data.key) && valid))
            data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end
endmodule
`default_nettype wire

### hdl/sorted_key_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Contents
// req     | in        | tdata: req_type, member_key, name_low, name_mid, name_high, gender_male
// rsp     | out       | tdata: status, position, record_key, names, rec_gender; tlast
// Insert, remove, lookup: request taken, cell row shifts in that
// same cycle, result registered and offered on the next.
// List: one result per stored entry, walked by a counter over the cell row.
// Reset clears the entry count and control only; cell contents stay undefined.
// A stalled result holds the row; no new request is taken until it leaves.
module sorted_key_table_core #(
   parameter int CAPACITY = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // req_type[1:0], member_key[33:2], name_low[97:34], name_mid[161:98],
   // name_high[185:162], gender_male[186], zero fill
   input  wire logic [191:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[2:0], position[8:3], record_key[40:9], rec_name_low[104:41],
   // rec_name_mid[168:105], rec_name_high[192:169], rec_gender[193], zero fill
   output logic [199:0]      rsp_tdata,
   output logic              rsp_tlast
);
   import skt_pkg::*;
   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int IdxW = $clog2(CAPACITY);

   state_type            state_ff, state_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [CntW-1:0]      walk_ff, walk_in;
   logic [199:0]         out_ff, out_in;
   logic                 last_ff, last_in;

   logic [1:0]           r_type;
   record_type           r_rec;
   cell_cmd_type         cmd;
   record_type           cell_data [CAPACITY];
   logic [CAPACITY-1:0]  cell_gt, cell_match, cell_valid;
   logic                 accept;
   logic                 found;
   logic [IdxW-1:0]      hit_idx;

   assign r_type      = req_tdata[1:0];
   assign r_rec.key    = req_tdata[33:2];
   assign r_rec.name   = req_tdata[185:34];
   assign r_rec.gender = req_tdata[186];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff != S_IDLE);
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = last_ff;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : gen_cell
         assign cell_valid[g] = (CntW'(g) < count_ff);
         skt_cell u_cell (
            .clock        (clock),
            .cmd          (cmd),
            .valid        (cell_valid[g]),
            .left_valid   (g == 0 ? 1'b0 : cell_valid[(g == 0) ? 0 : g-1]),
            .left_greater (g == 0 ? 1'b0 : cell_gt[(g == 0) ? 0 : g-1]),
            .left_data    (cell_data[(g == 0) ? 0 : g-1]),
            .right_data   (cell_data[(g == CAPACITY-1) ? g : g+1]),
            .greater      (cell_gt[g]),
            .match        (cell_match[g]),
            .data         (cell_data[g])
         );
      end
   endgenerate

   // match encoder
   always_comb begin
      found   = 1'b0;
      hit_idx = '0;
      for (int i = CAPACITY-1; i >= 0; i--) begin
         if (cell_match[i]) begin
            found   = 1'b1;
            hit_idx = IdxW'(i);
         end
      end
   end

   function automatic logic [199:0] pack_rsp(status_type st, logic [PosWidth-1:0] pos,
                                             record_type rec);
      logic [199:0] v;
      v = '0;
      v[2:0]     = st;
      v[8:3]     = pos;
      v[40:9]    = rec.key;
      v[192:41]  = rec.name;
      v[193]     = rec.gender;
      return v;
   endfunction

   always_comb begin
      record_type err_rec;
      record_type hit_rec;
      state_in = state_ff;
      count_in = count_ff;
      walk_in  = walk_ff;
      out_in   = out_ff;
      last_in  = last_ff;
      cmd.insert = 1'b0;
      cmd.remove = 1'b0;
      cmd.data   = r_rec;
      err_rec        = '0;
      err_rec.key    = r_rec.key;
      hit_rec        = cell_data[hit_idx];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_OUT;
               last_in  = 1'b1;
               if (r_type == REQ_INSERT) begin
                  if (r_rec.key == '0) out_in = pack_rsp(ST_BADKEY, '0, err_rec);
                  else if (found) out_in = pack_rsp(ST_DUP, '0, err_rec);
                  else if (count_ff >= CntW'(CAPACITY))
                     out_in = pack_rsp(ST_FULL, '0, err_rec);
                  else begin
                     cmd.insert = 1'b1;
                     count_in   = count_ff + 1'b1;
                     out_in     = pack_rsp(ST_OK, '0, r_rec);
                  end
               end else if (count_ff == '0) begin
                  if (r_type == REQ_LIST) err_rec.key = '0;
                  out_in = pack_rsp(ST_EMPTY, '0, err_rec);
               end else if (r_type == REQ_LIST) begin
                  out_in   = pack_rsp(ST_OK, 6'd1, cell_data[0]);
                  last_in  = (count_ff == CntW'(1));
                  walk_in  = CntW'(1);
                  state_in = S_LIST;
               end else if (!found) begin
                  out_in = pack_rsp(ST_NOTFOUND, '0, err_rec);
               end else if (r_type == REQ_LOOKUP) begin
                  out_in = pack_rsp(ST_OK, 6'({1'b0, hit_idx} + 1'b1), hit_rec);
               end else begin
                  cmd.remove = 1'b1;
                  count_in   = count_ff - 1'b1;
                  out_in     = pack_rsp(ST_OK, '0, hit_rec);
               end
            end
         end
         S_LIST: begin
            if (rsp_tready) begin
               if (last_ff) state_in = S_IDLE;
               else begin
                  out_in  = pack_rsp(ST_OK, 6'(walk_ff + 1'b1),
                                     cell_data[walk_ff[IdxW-1:0]]);
                  last_in = (walk_ff + 1'b1 == count_ff);
                  walk_in = walk_ff + 1'b1;
               end
            end
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         walk_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         walk_ff  <= walk_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end
endmodule
`default_nettype wire

### tb/tb_sorted_key_table_core.sv
`timescale 1ns / 1ps
module tb_sorted_key_table_core;
   import skt_pkg::*;

   localparam int Depth = 32;

   typedef struct {
      status_type  status;
      logic [5:0]  position;
      logic [31:0] key;
      logic [63:0] nlo;
      logic [63:0] nmid;
      logic [23:0] nhigh;
      logic        gender;
      logic        last;
   } rsp_item_type;

   // Shadow copy of the sorted table; computes expected responses.
   class table_scoreboard;
      logic [31:0] keys[$];
      logic [63:0] nlo[$];
      logic [63:0] nmid[$];
      logic [23:0] nhigh[$];
      logic        gen[$];
      rsp_item_type pending[$];
      int          errors;
      int          checked;

      function void push_rec(status_type st, logic [5:0] pos, int i, logic last);
         rsp_item_type r;
         r.status = st; r.position = pos; r.key = keys[i]; r.nlo = nlo[i];
         r.nmid = nmid[i]; r.nhigh = nhigh[i]; r.gender = gen[i]; r.last = last;
         pending.push_back(r);
      endfunction

      function void push_err(status_type st, logic [31:0] k);
         rsp_item_type r;
         r.status = st; r.position = 0; r.key = k; r.nlo = 0; r.nmid = 0;
         r.nhigh = 0; r.gender = 0; r.last = 1;
         pending.push_back(r);
      endfunction

      function int find(logic [31:0] k);
         foreach (keys[i]) if (keys[i] == k) return i;
         return -1;
      endfunction

      function void note_request(req_kind_type op, logic [31:0] k, logic [63:0] lo,
                                 logic [63:0] mid, logic [23:0] hi, logic g);
         int i;
         i = 0;
         if (op == REQ_INSERT) begin
            if (k == 0) push_err(ST_BADKEY, k);
            else if (find(k) >= 0) push_err(ST_DUP, k);
            else if (keys.size() >= Depth) push_err(ST_FULL, k);
            else begin
               while (i < keys.size() && k > keys[i]) i++;
               keys.insert(i, k); nlo.insert(i, lo); nmid.insert(i, mid);
               nhigh.insert(i, hi); gen.insert(i, g);
               push_rec(ST_OK, 0, i, 1);
            end
         end else if (keys.size() == 0) begin
            push_err(ST_EMPTY, op == REQ_LIST ? 32'd0 : k);
         end else if (op == REQ_LIST) begin
            foreach (keys[j]) push_rec(ST_OK, 6'(j + 1), j, j + 1 == keys.size());
         end else begin
            i = find(k);
            if (i < 0) push_err(ST_NOTFOUND, k);
            else if (op == REQ_LOOKUP) push_rec(ST_OK, 6'(i + 1), i, 1);
            else begin
               push_rec(ST_OK, 0, i, 1);
               keys.delete(i); nlo.delete(i); nmid.delete(i);
               nhigh.delete(i); gen.delete(i);
            end
         end
      endfunction

      function void check_response(logic [199:0] d, logic tl);
         rsp_item_type e;
         if (pending.size() == 0) begin
            $error("unexpected response, data %h", d);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (d[2:0] !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, d[2:0]); errors++;
         end
         if (d[8:3] !== e.position) begin
            $error("position: expected %0d, actual %0d", e.position, d[8:3]); errors++;
         end
         if (d[40:9] !== e.key) begin
            $error("record_key: expected %h, actual %h", e.key, d[40:9]); errors++;
         end
         if (d[104:41] !== e.nlo) begin
            $error("rec_name_low: expected %h, actual %h", e.nlo, d[104:41]); errors++;
         end
         if (d[168:105] !== e.nmid) begin
            $error("rec_name_mid: expected %h, actual %h", e.nmid, d[168:105]); errors++;
         end
         if (d[192:169] !== e.nhigh) begin
            $error("rec_name_high: expected %h, actual %h", e.nhigh, d[192:169]); errors++;
         end
         if (d[193] !== e.gender) begin
            $error("rec_gender: expected %0d, actual %0d", e.gender, d[193]); errors++;
         end
         if (tl !== e.last) begin
            $error("last_result: expected %0d, actual %0d", e.last, tl); errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [199:0] rsp_tdata;
   logic         rsp_tlast;

   table_scoreboard sb = new();
   bit   calm;          // no idling on either side while set
   bit   sink_hold;     // long receiver hold-off request
   bit   src_done;
   int   n_requests;
   int   list_items;

   always #5 clock = ~clock;

   sorted_key_table_core #(.CAPACITY(Depth)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   // Offer one request; hold it until accepted, then note it in the table model.
   task automatic send_request(req_kind_type op, logic [31:0] k, logic [63:0] lo,
                               logic [63:0] mid, logic [23:0] hi, logic g);
      if (!calm && $urandom_range(99) < 28) begin
         req_tvalid <= 0;
         do @(posedge clock); while (!calm && $urandom_range(99) < 28);
      end
      req_tvalid <= 1;
      req_tdata  <= {5'd0, g, hi, mid, lo, k, op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, k, lo, mid, hi, g);
      n_requests++;
      if (op == REQ_LIST) list_items++;
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   // Key from a small pool so duplicates, hits and misses occur often.
   function automatic logic [31:0] pool_key();
      case ($urandom_range(9))
         0:       return $urandom();
         1:       return 32'hFFFF_FFFF - $urandom_range(3);
         default: return $urandom_range(1, 48);
      endcase
   endfunction

   task automatic send_random(int fill_bias);
      req_kind_type op;
      int r;
      r = $urandom_range(99);
      if (r < fill_bias) op = REQ_INSERT;
      else if (r < 75) op = req_kind_type'($urandom_range(1, 2));
      else if (r < 82) op = REQ_LIST;
      else op = req_kind_type'($urandom_range(3));
      send_request(op, ($urandom_range(30) == 0) ? 32'd0 : pool_key(),
                   rnd64(), rnd64(), 24'($urandom()), 1'($urandom()));
   endtask

   // Receiver: random stalls, calm stretches, one long hold-off on request.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tlast);
      rsp_tready <= !sink_hold && (calm || $urandom_range(99) >= 28);
   end

   initial begin : hold_off
      int cnt;
      sink_hold = 0;
      wait (n_requests >= 150);
      sink_hold = 1;
      cnt = 0;
      while (cnt < 400) begin
         @(posedge clock);
         cnt++;
      end
      sink_hold = 0;
   end

   initial begin : stimulus
      logic [63:0] ones;
      ones = '1;
      calm = 0; src_done = 0; n_requests = 0; list_items = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty table on every non-insert operation
      send_request(REQ_LIST, 32'h1234, 0, 0, 0, 0);
      send_request(REQ_REMOVE, 32'h5, 0, 0, 0, 0);
      send_request(REQ_LOOKUP, 32'h0, 0, 0, 0, 0);
      // field extremes, zero key, duplicate
      send_request(REQ_INSERT, 32'h0, ones, ones, '1, 1);
      send_request(REQ_INSERT, 32'hFFFF_FFFF, ones, ones, '1, 1);
      send_request(REQ_INSERT, 32'h1, 0, 0, 0, 0);
      send_request(REQ_INSERT, 32'h8000_0000, 64'hA5A5, 64'h5A5A, 24'hC3C3C3, 0);
      send_request(REQ_INSERT, 32'h1, ones, 0, '1, 1);
      send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0);
      send_request(REQ_LOOKUP, 32'h0, 0, 0, 0, 0);
      send_request(REQ_LOOKUP, 32'h77, 0, 0, 0, 0);
      send_request(REQ_LIST, 0, 0, 0, 0, 0);
      send_request(REQ_REMOVE, 32'h8000_0000, 0, 0, 0, 0);
      send_request(REQ_REMOVE, 32'h9, 0, 0, 0, 0);
      send_request(REQ_LIST, 0, 0, 0, 0, 0);
      // fill to capacity, then overflow and list the full table
      for (int i = 0; i < Depth; i++)
         send_request(REQ_INSERT, 32'd1000 + 32'(($urandom_range(1) ? i : 63 - i) * 3),
                      rnd64(), rnd64(), 24'($urandom()), 1'($urandom()));
      send_request(REQ_INSERT, 32'h2, 0, 0, 0, 0);
      send_request(REQ_LIST, 0, 0, 0, 0, 0);
      // drain it again
      while (sb.keys.size() > 0)
         send_request(REQ_REMOVE, sb.keys[$urandom_range(sb.keys.size() - 1)],
                      0, 0, 0, 0);

      // random phase: alternate filling and draining bias
      for (int n = 0; n < 240; n++) begin
         calm = (n >= 100 && n < 160);
         send_random(((n / 40) % 2 == 0) ? 70 : 25);
      end
      req_tvalid <= 0;
      calm = 0;
      src_done = 1;
   end

   initial begin : finish_run
      wait (src_done);
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Ran %0d requests (%0d list walks), checked %0d responses.",
               n_requests, list_items, sb.checked);
      $display("Covered empty, full, duplicate, bad key and missing key cases.");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end
endmodule

### sim.f
hdl/skt_pkg.sv
hdl/skt_cell.sv
hdl/sorted_key_table_core.sv
tb/tb_sorted_key_table_core.sv
